// ===== src/sfa_pkg.sv =====
// Shared types and constants of the start/end code frame assembler.
// No dependencies; the channels, the assembler unit and the checker use it by scoped names.
package sfa_pkg;

  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 1;

  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_START_CODE = 1'b0;
  localparam cfg_idx_t CFG_END_CODE   = 1'b1;

  // Register values after reset.
  localparam byte_t START_CODE_RST = 8'h01;
  localparam byte_t END_CODE_RST   = 8'hFE;

  // Main sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FRAME = 3'b010,
    ST_PLAY  = 3'b100
  } state_t;

endpackage

// ===== src/sfa_channels.sv =====
// Valid/ready channel interfaces of the frame assembler: received bytes,
// frame bytes out and configuration writes. Depends on sfa_pkg.
interface sfa_in_if;
  logic                valid;
  logic                ready;
  logic                receive_ok;
  sfa_pkg::byte_t      rx_byte;
  modport source (output valid, receive_ok, rx_byte, input ready);
  modport sink   (input valid, receive_ok, rx_byte, output ready);
endinterface

interface sfa_out_if;
  logic                valid;
  logic                ready;
  sfa_pkg::byte_t      out_byte;
  logic                last_byte;
  modport source (output valid, out_byte, last_byte, input ready);
  modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

interface sfa_cfg_if;
  logic                valid;
  logic                ready;
  sfa_pkg::cfg_idx_t   index;
  sfa_pkg::byte_t      data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/sfa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/start_end_code_frame_assembler_unit.sv =====
// Start/end code frame assembler: collects received bytes from the start code
// through the end code in a frame RAM and replays length-checked frames.
// Depends on sfa_pkg, sfa_channels and sfa_ram.
//
// Usage: every received byte is one input item and is taken in a single
// cycle while the block collects a frame; items flagged with receive_ok low
// are ignored. A frame opens at the start code and closes at the end code.
// When it closes, byte 2 of the frame must equal the frame's length in bytes,
// start and end code included, and the frame must hold at least three bytes;
// otherwise it is dropped without any output. A frame that would need more
// than FRAME_DEPTH bytes is discarded as soon as the last free entry is asked
// for a data byte. An accepted frame of N bytes is replayed from the frame RAM
// as N result items, the end code last and flagged by last_byte. During the
// replay the input is held off; each byte is read from the RAM into the
// output register, and no new read is issued while one is in flight or a
// stalled result waits. The input opens again the cycle after the last read
// is issued, while the final byte may still wait in the output register. The
// configuration registers are written through their own channel, which is
// always ready, and must only be written while no frame is in progress.
module start_end_code_frame_assembler_unit #(
  parameter int FRAME_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  sfa_in_if.sink           in_ch,
  sfa_out_if.source        out_ch,
  sfa_cfg_if.sink          cfg_ch
);

  localparam int ADDR_W = $clog2(FRAME_DEPTH);
  localparam int CNT_W  = $clog2(FRAME_DEPTH + 1);
  localparam int BW     = sfa_pkg::BYTE_W;

  // Configuration registers.
  sfa_pkg::byte_t start_code_r;
  sfa_pkg::byte_t end_code_r;

  // Sequencer and frame bookkeeping.
  sfa_pkg::state_t   state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;     // bytes stored so far
  logic [CNT_W-1:0]  len_r, len_nxt;         // length of the frame to replay
  logic [CNT_W-1:0]  rd_ptr_r, rd_ptr_nxt;   // next entry to read during replay
  sfa_pkg::byte_t    byte2_r, byte2_nxt;     // copy of the length byte

  // Read in flight and output register.
  logic              pend_r, pend_nxt;
  logic              pend_last_r, pend_last_nxt;
  logic              out_valid_r, out_valid_nxt;
  sfa_pkg::byte_t    out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;

  // RAM ports.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  sfa_pkg::byte_t    ram_wdata;
  logic              ram_re;
  sfa_pkg::byte_t    ram_rdata;

  logic              in_take;
  sfa_pkg::byte_t    rx_b;
  logic [CNT_W-1:0]  total;
  sfa_pkg::byte_t    len_byte;
  logic              rd_last;

  sfa_ram #(
    .WIDTH (BW),
    .DEPTH (FRAME_DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_ptr_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // The input is held off only while a frame is read back from the RAM, so
  // the RAM's single write port and read port never serve the same frame.
  assign in_ch.ready = (state_r != sfa_pkg::ST_PLAY);
  assign in_take     = in_ch.valid && in_ch.ready && in_ch.receive_ok;
  assign rx_b        = in_ch.rx_byte;
  assign total       = count_r + CNT_W'(1);
  // When the end code itself lands on entry 2 it is the length byte.
  assign len_byte    = (count_r == CNT_W'(2)) ? rx_b : byte2_r;
  assign rd_last     = ((rd_ptr_r + CNT_W'(1)) == len_r);

  // A read is issued only when the output register is sure to be free by
  // the time the data returns, so no read result ever has to be parked.
  assign ram_re = (state_r == sfa_pkg::ST_PLAY) && !pend_r &&
                  (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    len_nxt       = len_r;
    rd_ptr_nxt    = rd_ptr_r;
    byte2_nxt     = byte2_r;
    ram_we        = 1'b0;
    ram_waddr     = count_r[ADDR_W-1:0];
    ram_wdata     = rx_b;

    case (state_r)
      sfa_pkg::ST_IDLE: begin
        if (in_take && (rx_b == start_code_r)) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          count_nxt = CNT_W'(1);
          state_nxt = sfa_pkg::ST_FRAME;
        end
      end
      sfa_pkg::ST_FRAME: begin
        if (in_take) begin
          if (rx_b != end_code_r) begin
            if (count_r >= CNT_W'(FRAME_DEPTH - 1)) begin
              // Only the entry kept for the end code is left: discard.
              count_nxt = '0;
              state_nxt = sfa_pkg::ST_IDLE;
            end else begin
              ram_we    = 1'b1;
              count_nxt = total;
              if (count_r == CNT_W'(2)) begin
                byte2_nxt = rx_b;
              end
            end
          end else begin
            ram_we    = 1'b1;
            count_nxt = '0;
            if ((total >= CNT_W'(3)) && (len_byte == BW'(total))) begin
              len_nxt    = total;
              rd_ptr_nxt = '0;
              state_nxt  = sfa_pkg::ST_PLAY;
            end else begin
              state_nxt  = sfa_pkg::ST_IDLE;
            end
          end
        end
      end
      sfa_pkg::ST_PLAY: begin
        if (ram_re) begin
          rd_ptr_nxt = rd_ptr_r + CNT_W'(1);
          if (rd_last) begin
            state_nxt = sfa_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = sfa_pkg::ST_IDLE;
        count_nxt = '0;
      end
    endcase
  end

  // Output register: loaded from the RAM's registered read data while pend_r marks a read in flight.
  always_comb begin
    pend_nxt      = ram_re;
    pend_last_nxt = ram_re ? rd_last : pend_last_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (pend_r) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = ram_rdata;
      out_last_nxt  = pend_last_r;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sfa_pkg::ST_IDLE;
      count_r      <= '0;
      rd_ptr_r     <= '0;
      len_r        <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      start_code_r <= sfa_pkg::START_CODE_RST;
      end_code_r   <= sfa_pkg::END_CODE_RST;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      len_r       <= len_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          sfa_pkg::CFG_START_CODE: start_code_r <= cfg_ch.data;
          sfa_pkg::CFG_END_CODE:   end_code_r   <= cfg_ch.data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    byte2_r     <= byte2_nxt;
    pend_last_r <= pend_last_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.last_byte = out_last_r;

endmodule

// ===== src/sfa_checker.sv =====
// Port-level checks of the frame assembler, bound to its top level.
// Depends on sfa_pkg and start_end_code_frame_assembler_unit.
module sfa_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           in_receive_ok,
  input logic           out_valid,
  input logic           out_ready,
  input sfa_pkg::byte_t out_byte,
  input logic           out_last_byte
);

  // Nothing is offered on the result side right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // An item received in error never starts a replay.
  a_bad_item_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_receive_ok) |=> in_ready)
    else $error("ignored item closed the input");

  // The input only closes right after a good item was taken.
  a_close_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid && in_receive_ok))
    else $error("input closed without a received item");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_byte) && $stable(out_last_byte)))
    else $error("stalled result changed");

endmodule

bind start_end_code_frame_assembler_unit sfa_checker u_sfa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_receive_ok (in_ch.receive_ok),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_byte      (out_ch.out_byte),
  .out_last_byte (out_ch.last_byte)
);
